/* hw/rtl/stwt_pkg.sv */
// Shared types, codes and defaults for the session table with timeout.
// Used by the channel interfaces, the controller and the core module.
package stwt_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_KEY_BITS      = 64;
    localparam int DEF_TIME_BITS     = 32;

    // Fixed field widths on the channels and the configuration port.
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 64;
    localparam int TIME_W     = 32;
    localparam int TAG_W      = 8;
    localparam int MSG_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOGIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOGOUT = 2'd2;

    // Message codes.
    localparam logic [MSG_W-1:0] MSG_NONE    = 2'd0;
    localparam logic [MSG_W-1:0] MSG_WELCOME = 2'd1;
    localparam logic [MSG_W-1:0] MSG_BYE     = 2'd2;
    localparam logic [MSG_W-1:0] MSG_NO_SESS = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TTL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASSIVE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DEFAULT_TTL = 32'd3600;

    // Live configuration handed to the controller.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] ttl;
        logic                  fixed_expiry;
        logic                  passive_mode;
    } t_cfg;

    // One result beat as produced by the controller.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             granted;
        logic [MSG_W-1:0] msg;
        logic             failed;
    } t_result;

endpackage

/* hw/rtl/stwt_if.sv */
// Valid/ready channel interfaces for requests and replies.
// Field widths come from stwt_pkg.
interface stwt_req_if import stwt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  session_key;
    logic [TIME_W-1:0] current_time;
    logic [TAG_W-1:0]  request_tag;

    modport source (output valid, command, session_key, current_time, request_tag,
                    input ready);
    modport sink   (input valid, command, session_key, current_time, request_tag,
                    output ready);
endinterface

interface stwt_rsp_if import stwt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] reply_tag;
    logic             granted;
    logic [MSG_W-1:0] message_code;
    logic             store_failed;

    modport source (output valid, reply_tag, granted, message_code, store_failed,
                    input ready);
    modport sink   (input valid, reply_tag, granted, message_code, store_failed,
                    output ready);
endinterface

/* hw/rtl/stwt_mem.sv */
// Single-port-write, single-port-read table memory with a registered read.
// Holds one word per session entry; no dependencies beyond its parameters.
module stwt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 97,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_entries [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entries[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_entries[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/stwt_ctrl.sv */
// Controller: clearing pass, sequential table scan, decision and write-back.
// Depends on stwt_pkg, stwt_req_if and the table memory ports.
module stwt_ctrl import stwt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int TIME_BITS     = DEF_TIME_BITS,
    localparam int AW           = $clog2(TABLE_ENTRIES),
    localparam int EW           = 1 + KEY_BITS + TIME_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stwt_req_if.sink          i_req,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output logic              o_mem_wr_en,
    output logic [AW-1:0]     o_mem_wr_addr,
    output logic [EW-1:0]     o_mem_wr_data,
    output logic [AW-1:0]     o_mem_rd_addr,
    input  logic [EW-1:0]     i_mem_rd_data
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_chk_valid, n_chk_valid;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic          r_found, n_found;
    logic          r_hit_live, n_hit_live;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic          r_free_found, n_free_found;
    logic [AW-1:0] r_free_idx, n_free_idx;
    t_result       r_res, n_res;

    // Captured request payload.
    logic [CMD_W-1:0]     r_cmd;
    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_BITS-1:0] r_now;
    logic [TAG_W-1:0]     r_tag;

    logic                 req_acc;
    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [TIME_BITS-1:0] rd_stamp;
    logic [TIME_BITS-1:0] age;
    logic                 entry_live;
    logic                 entry_hit;
    logic                 store_ok;
    logic [AW-1:0]        store_idx;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    // Payload capture at acceptance.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_cmd <= i_req.command;
            r_key <= i_req.session_key[KEY_BITS-1:0];
            r_now <= TIME_BITS'(i_req.current_time);
            r_tag <= i_req.request_tag;
        end
    end

    // Fields of the entry returned by the memory.
    assign rd_valid = i_mem_rd_data[EW-1];
    assign rd_key   = i_mem_rd_data[TIME_BITS +: KEY_BITS];
    assign rd_stamp = i_mem_rd_data[TIME_BITS-1:0];

    // A session is live while its stamp plus the TTL, without wrap, reaches now.
    assign age        = r_now - rd_stamp;
    assign entry_live = (r_now <= rd_stamp) || (64'(age) <= 64'(i_cfg.ttl));
    assign entry_hit  = rd_valid && (rd_key == r_key);

    assign store_ok  = r_found || r_free_found;
    assign store_idx = r_found ? r_hit_idx : r_free_idx;

    assign o_mem_rd_addr = r_idx;

    // Next-state logic for the sequencer.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_issue_done  = r_issue_done;
        n_chk_valid   = 1'b0;
        n_chk_idx     = r_idx;
        n_found       = r_found;
        n_hit_live    = r_hit_live;
        n_hit_idx     = r_hit_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_res         = r_res;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_idx;
        o_mem_wr_data = {1'b1, r_key, r_now};
        case (r_state)
            S_CLEAR: begin
                // Sweep the table once, marking every entry free.
                o_mem_wr_en   = 1'b1;
                o_mem_wr_data = '0;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                // Issue one read a cycle and inspect the entry read last cycle.
                n_chk_valid = !r_issue_done;
                if (!r_issue_done) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                if (r_chk_valid) begin
                    if (entry_hit && !r_found) begin
                        n_found    = 1'b1;
                        n_hit_idx  = r_chk_idx;
                        n_hit_live = entry_live;
                    end
                    if ((!rd_valid || !entry_live) && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                    if (r_chk_idx == LAST_IDX) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                // Apply the command to the table and form the reply.
                n_state       = S_RESP;
                n_res.tag     = r_tag;
                n_res.failed  = 1'b0;
                n_res.granted = 1'b1;
                n_res.msg     = MSG_NONE;
                case (r_cmd)
                    CMD_LOGOUT: begin
                        o_mem_wr_en   = r_found;
                        o_mem_wr_addr = r_hit_idx;
                        o_mem_wr_data = {1'b0, r_key, r_now};
                        n_res.msg     = MSG_BYE;
                    end
                    CMD_LOGIN: begin
                        o_mem_wr_en   = store_ok;
                        o_mem_wr_addr = store_idx;
                        n_res.failed  = !store_ok;
                        n_res.msg     = MSG_WELCOME;
                    end
                    default: begin
                        if (r_found && r_hit_live) begin
                            // Active session: renew unless expiry is fixed.
                            o_mem_wr_en   = !i_cfg.fixed_expiry;
                            o_mem_wr_addr = r_hit_idx;
                        end else if (i_cfg.passive_mode) begin
                            o_mem_wr_en   = store_ok;
                            o_mem_wr_addr = store_idx;
                            n_res.failed  = !store_ok;
                            n_res.granted = 1'b0;
                            n_res.msg     = MSG_WELCOME;
                        end else begin
                            n_res.granted = 1'b0;
                            n_res.msg     = MSG_NO_SESS;
                        end
                    end
                endcase
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_chk_valid  <= n_chk_valid;
            r_found      <= n_found;
            r_free_found <= n_free_found;
        end
    end

    // Scan bookkeeping and reply payload.
    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_hit_live <= n_hit_live;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    // The table is written only by the clearing pass or the decision step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> (r_state == S_CLEAR) || (r_state == S_DECIDE))
        else $error("table written outside clear or decide");

    // An accepted request starts a scan from the first entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == S_SCAN) && (r_idx == '0) && !r_issue_done)
        else $error("scan did not start at entry zero");

    // The decision step is followed by exactly one reply offer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> o_res_valid)
        else $error("no reply after decision");

    // Once the reply beat is taken, the next request can be accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> i_req.ready)
        else $error("not ready after reply");
`endif

endmodule

/* hw/rtl/session_table_with_timeout_core.sv */
// Session table with timeout: configuration registers, output register and
// the controller/memory pair. A request beat passes the one-entry-per-cycle
// table scan, the decision step, the reply state and the output register.
// No new request is taken until the controller has handed on the last reply.
// After reset a clearing pass over every table entry runs before the first
// request is taken; configuration returns to its defaults at reset.
module session_table_with_timeout_core import stwt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int TIME_BITS     = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stwt_req_if.sink              i_req,
    stwt_rsp_if.source            o_rsp,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 1 + KEY_BITS + TIME_BITS;

    logic [CFG_DATA_W-1:0] r_ttl;
    logic                  r_fixed;
    logic                  r_passive;
    t_cfg                  cfg;

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          r_out_valid;
    t_result       r_out;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [EW-1:0] mem_rd_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl     <= DEFAULT_TTL;
            r_fixed   <= 1'b0;
            r_passive <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TTL:     r_ttl     <= i_cfg_data;
                REG_FIXED:   r_fixed   <= i_cfg_data[0];
                REG_PASSIVE: r_passive <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.ttl          = r_ttl;
    assign cfg.fixed_expiry = r_fixed;
    assign cfg.passive_mode = r_passive;

    stwt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg         (cfg),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    stwt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Output register: takes a reply beat whenever it is empty or draining.
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.reply_tag    = r_out.tag;
    assign o_rsp.granted      = r_out.granted;
    assign o_rsp.message_code = r_out.msg;
    assign o_rsp.store_failed = r_out.failed;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for session_table_with_timeout_core.
// Drives request beats and configuration writes, predicts each reply with a
// local session table model. Depends on stwt_pkg and the stwt channel interfaces.
`timescale 1ns / 100ps

module testbench;
    import stwt_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          TABLE_ENTRIES = DEF_TABLE_ENTRIES;
    localparam int          REPLY_LATENCY = TABLE_ENTRIES + 4;
    localparam int          CYCLE_LIMIT   = 1_500_000;
    localparam int          PHASE_COUNT   = 9;
    localparam int          PHASE_ITEMS   = 150;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stwt_req_if req_ch ();
    stwt_rsp_if rsp_ch ();

    session_table_with_timeout_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Mirror of the session table and the live settings.
    logic [KEY_W-1:0]      slot_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]     slot_stamp [TABLE_ENTRIES];
    bit                    slot_used  [TABLE_ENTRIES];
    logic [CFG_DATA_W-1:0] live_ttl;
    bit                    live_fixed_expiry;
    bit                    live_passive;

    t_result awaited_replies[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    bit      gaps_on        = 1'b1;
    bit      stalls_on      = 1'b1;

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly short pauses, now and then a long one.
    function automatic int pick_idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(40, 120);
    endfunction

    // A session is live while stamp + TTL reaches the current time, with no wrap.
    function automatic bit session_live(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
        if (now <= stamp)
            return 1'b1;
        return (now - stamp) <= live_ttl;
    endfunction

    function automatic int find_session(logic [KEY_W-1:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Re-stamps a known key in place, otherwise takes the lowest free or
    // expired slot. Returns 0 when the table is full of live sessions.
    function automatic bit stamp_session(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
        int slot;
        slot = find_session(key);
        for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (!slot_used[i] || !session_live(slot_stamp[i], now))
                slot = i;
        if (slot < 0)
            return 1'b0;
        slot_key[slot]   = key;
        slot_stamp[slot] = now;
        slot_used[slot]  = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_result predict_session_reply(logic [CMD_W-1:0] cmd,
                                                      logic [KEY_W-1:0] key,
                                                      logic [TIME_W-1:0] now,
                                                      logic [TAG_W-1:0] tag);
        t_result reply;
        int      slot;
        reply.tag     = tag;
        reply.granted = 1'b1;
        reply.msg     = MSG_NONE;
        reply.failed  = 1'b0;
        case (cmd)
            CMD_LOGOUT: begin
                slot = find_session(key);
                if (slot >= 0)
                    slot_used[slot] = 1'b0;
                reply.msg = MSG_BYE;
            end
            CMD_LOGIN: begin
                reply.failed = !stamp_session(key, now);
                reply.msg    = MSG_WELCOME;
            end
            default: begin
                // Checks, and the unused command code, which behaves as a check.
                slot = find_session(key);
                if (slot >= 0 && session_live(slot_stamp[slot], now)) begin
                    if (!live_fixed_expiry)
                        slot_stamp[slot] = now;
                end else if (live_passive) begin
                    reply.granted = 1'b0;
                    reply.msg     = MSG_WELCOME;
                    reply.failed  = !stamp_session(key, now);
                end else begin
                    reply.granted = 1'b0;
                    reply.msg     = MSG_NO_SESS;
                end
            end
        endcase
        return reply;
    endfunction

    // Sends one request beat after an optional gap and records its expected reply.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now, input logic [TAG_W-1:0] tag);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_idle_cycles() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.session_key  <= key;
        req_ch.current_time <= now;
        req_ch.request_tag  <= tag;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        awaited_replies.push_back(predict_session_reply(cmd, key, now, tag));
    endtask

    // Lets every outstanding reply arrive so that the block is idle.
    task automatic settle_idle();
        req_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; only called while idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ttl, input bit fixed_expiry,
                                  input bit passive);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TTL;
        cfg_data  <= ttl;
        @(posedge i_clk);
        cfg_index <= REG_FIXED;
        cfg_data  <= CFG_DATA_W'(fixed_expiry);
        @(posedge i_clk);
        cfg_index <= REG_PASSIVE;
        cfg_data  <= CFG_DATA_W'(passive);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        live_ttl          = ttl;
        live_fixed_expiry = fixed_expiry;
        live_passive      = passive;
    endtask

    // Login, renewal, expiry, logout and the unused command under reset settings.
    task automatic test_session_basics();
        send_request(CMD_CHECK,  64'd0,          32'd0,    8'h00);
        send_request(CMD_LOGIN,  {KEY_W{1'b1}},  32'd100,  8'hFF);
        send_request(CMD_CHECK,  64'd0,          32'd3600, 8'h01);
        send_request(CMD_CHECK,  64'd0,          32'd7201, 8'h02);
        send_request(CMD_LOGOUT, {KEY_W{1'b1}},  32'd7201, 8'h80);
        send_request(CMD_LOGOUT, {KEY_W{1'b1}},  32'd7202, 8'h7F);
        send_request(CMD_UNUSED, 64'd0,          32'd7203, 8'h55);
    endtask

    // Checks must not renew the stamp once expiry is fixed.
    task automatic test_fixed_expiry();
        settle_idle();
        apply_settings(DEFAULT_TTL, 1'b1, 1'b1);
        send_request(CMD_LOGIN, 64'h5555_5555_5555_5555, 32'd1000, 8'hAA);
        send_request(CMD_CHECK, 64'h5555_5555_5555_5555, 32'd4000, 8'h03);
        send_request(CMD_CHECK, 64'h5555_5555_5555_5555, 32'd4601, 8'h04);
        send_request(CMD_CHECK, 64'h5555_5555_5555_5555, 32'd500,  8'h05);
    endtask

    // Unknown sessions are refused; a stamp ahead of the clock counts as live.
    task automatic test_active_mode();
        settle_idle();
        apply_settings(DEFAULT_TTL, 1'b0, 1'b0);
        send_request(CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0,          8'h06);
        send_request(CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0,          8'h07);
        send_request(CMD_LOGIN, 64'hAAAA_AAAA_AAAA_AAAA, {TIME_W{1'b1}}, 8'h08);
        send_request(CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0,          8'h09);
    endtask

    // Zero TTL expires at the next second; the largest TTL never expires.
    task automatic test_ttl_extremes();
        settle_idle();
        apply_settings(32'd0, 1'b0, 1'b0);
        send_request(CMD_LOGIN, 64'h0123_4567_89AB_CDEF, 32'd50, 8'h0A);
        send_request(CMD_CHECK, 64'h0123_4567_89AB_CDEF, 32'd50, 8'h0B);
        send_request(CMD_CHECK, 64'h0123_4567_89AB_CDEF, 32'd51, 8'h0C);
        settle_idle();
        apply_settings({CFG_DATA_W{1'b1}}, 1'b0, 1'b1);
        send_request(CMD_LOGIN, 64'hFEDC_BA98_7654_3210, 32'd0,          8'h0D);
        send_request(CMD_CHECK, 64'hFEDC_BA98_7654_3210, {TIME_W{1'b1}}, 8'h0E);
    endtask

    // Phases of random traffic over a pool of keys, with a clock that mostly
    // moves forward so that sessions age, renew, expire and fill the table.
    task automatic test_random_sessions();
        logic [KEY_W-1:0]      key_pool [128];
        int                    pool_size;
        logic [CFG_DATA_W-1:0] ttl;
        bit                    fixed_expiry;
        bit                    passive;
        logic [TIME_W-1:0]     now;
        logic [TIME_W-1:0]     step_cap;
        logic [CMD_W-1:0]      cmd;
        logic [KEY_W-1:0]      key;
        int                    roll;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle_idle();
            fixed_expiry = 1'($urandom_range(0, 1));
            passive      = 1'($urandom_range(0, 1));
            case (phase)
                0: begin ttl = DEFAULT_TTL;        fixed_expiry = 1'b0; passive = 1'b1; end
                1: begin ttl = 32'd0;              fixed_expiry = 1'b1; passive = 1'b0; end
                2: begin ttl = {CFG_DATA_W{1'b1}}; fixed_expiry = 1'b0; passive = 1'b1; end
                3: begin ttl = $urandom_range(1, 50); fixed_expiry = 1'b1; passive = 1'b1; end
                4: begin ttl = 32'd1;              fixed_expiry = 1'b0; passive = 1'b1; end
                5: begin ttl = $urandom;           passive = 1'b0;                      end
                6: begin ttl = {CFG_DATA_W{1'b1}}; fixed_expiry = 1'b1; passive = 1'b0; end
                7: begin ttl = 32'd200;            fixed_expiry = 1'b0; passive = 1'b1; end
                default: ttl = $urandom_range(0, 5000);
            endcase
            apply_settings(ttl, fixed_expiry, passive);
            // One phase runs with neither side pausing.
            gaps_on   = (phase != 3);
            stalls_on = (phase != 3);
            pool_size = (phase % 3 == 0) ? 6 : ((phase % 3 == 1) ? 40 : 90);
            for (int k = 0; k < pool_size; k++)
                key_pool[k] = {$urandom, $urandom};
            step_cap = (ttl > 400) ? 32'd200 : ttl / 2 + 2;
            now      = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    now = now + $urandom_range(0, step_cap);
                else if (roll < 80)
                    now = now - $urandom_range(0, step_cap);
                else if (roll >= 92)
                    now = $urandom;
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    cmd = CMD_CHECK;
                else if (roll < 75)
                    cmd = CMD_LOGIN;
                else if (roll < 95)
                    cmd = CMD_LOGOUT;
                else
                    cmd = CMD_UNUSED;
                key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                send_request(cmd, key, now, TAG_W'($urandom_range(0, 255)));
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Reply side: ready drops for random stretches.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_idle_cycles() - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Each accepted reply beat is compared with the oldest expected reply.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: reply beat, expected none, actual tag %0h granted %0b",
                         $time, rsp_ch.reply_tag, rsp_ch.granted);
                $display("%0t: reply beat, actual msg %0d failed %0b",
                         $time, rsp_ch.message_code, rsp_ch.store_failed);
            end else begin
                want = awaited_replies.pop_front();
                compare_field("reply_tag",    want.tag,         rsp_ch.reply_tag);
                compare_field("granted",      8'(want.granted), 8'(rsp_ch.granted));
                compare_field("message_code", 8'(want.msg),     8'(rsp_ch.message_code));
                compare_field("store_failed", 8'(want.failed),  8'(rsp_ch.store_failed));
            end
        end
    end

    // Guard against a hung block.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_TTL;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_CHECK;
        req_ch.session_key  = '0;
        req_ch.current_time = '0;
        req_ch.request_tag  = '0;
        rsp_ch.ready        = 1'b0;
        // Model state after reset: empty table, default settings.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            slot_used[i] = 1'b0;
        live_ttl          = DEFAULT_TTL;
        live_fixed_expiry = 1'b0;
        live_passive      = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_session_basics();
        test_fixed_expiry();
        test_active_mode();
        test_ttl_extremes();
        test_random_sessions();

        settle_idle();
        repeat (REPLY_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/stwt_pkg.sv
hw/rtl/stwt_if.sv
hw/rtl/stwt_mem.sv
hw/rtl/stwt_ctrl.sv
hw/rtl/session_table_with_timeout_core.sv
tb/sv/testbench.sv
